[hw/rtl/jqkr_pkg.sv]
// Shared types and constants for the job queue with keyed removal.
// Depends on nothing; every other file of the block imports it.

package jqkr_pkg;

    // Queue depth and the widths that follow from it.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths of one word.
    localparam int FUNC_W   = 3;
    localparam int HANDLE_W = 16;
    localparam int PID_W    = 23;
    localparam int NAME_W   = 48;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_PUSH     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RM_PID   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RM_NAME  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd3;

    // One queue entry.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    pid;
        logic [NAME_W-1:0]   name;
    } entry_t;

    // Search request broadcast to every cell when a word is accepted.
    typedef struct packed {
        logic              capture;
        logic [FUNC_W-1:0] func;
        logic [PID_W-1:0]  pid;
        logic [NAME_W-1:0] name;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  count;
    } cell_cmd_t;

    // Update request broadcast to every cell in the execute cycle.
    typedef struct packed {
        logic             shift_en;
        logic             push_en;
        entry_t           push_data;
        logic [CNT_W-1:0] count;
    } cell_exec_t;

    // Signals handed from one cell to the next toward the tail.
    typedef struct packed {
        logic   found;
        entry_t sel;
    } chain_t;

endpackage

[hw/rtl/jqkr_cell.sv]
// One slot of the job queue: holds an entry, matches it against the key,
// and shifts toward the head when an earlier or its own slot is taken out.
// Depends on jqkr_pkg.

module jqkr_cell (
    input  logic                      clk,
    input  logic [jqkr_pkg::IDX_W-1:0] cell_idx,
    input  jqkr_pkg::cell_cmd_t       cmd,
    input  jqkr_pkg::cell_exec_t      exec,
    input  jqkr_pkg::chain_t          chain_in,
    output jqkr_pkg::chain_t          chain_out,
    input  jqkr_pkg::entry_t          right_entry,
    output jqkr_pkg::entry_t          entry
);
    import jqkr_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit_reg;
    logic   hit_next;
    logic   occupied;
    logic   first_hit;
    logic   is_tail;

    // Key compare against the incoming word, gated by occupancy.
    always_comb
    begin
        occupied = 32'(cell_idx) < 32'(cmd.count);
        hit_next = 1'b0;
        unique case (cmd.func)
            FUNC_POP:     hit_next = (cell_idx == '0);
            FUNC_RM_PID:  hit_next = (entry_reg.pid == cmd.pid);
            FUNC_RM_NAME: hit_next = (entry_reg.name == cmd.name);
            FUNC_READ:    hit_next = (32'(cmd.position) == 32'(cell_idx));
            default:      hit_next = 1'b0;
        endcase
        hit_next = hit_next & occupied;
    end

    // The hit is held for the execute cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hit_reg <= hit_next;
        end
    end

    // Only the first hit from the head counts; it drives the selected entry.
    always_comb
    begin
        first_hit       = hit_reg & ~chain_in.found;
        chain_out.found = chain_in.found | hit_reg;
        chain_out.sel   = first_hit ? entry_reg : chain_in.sel;
    end

    // Close the gap behind a removed slot, or take a pushed entry at the tail.
    always_comb
    begin
        is_tail    = 32'(cell_idx) == 32'(exec.count);
        entry_next = entry_reg;
        priority if (exec.shift_en && chain_out.found)
        begin
            entry_next = right_entry;
        end
        else if (exec.push_en && is_tail)
        begin
            entry_next = exec.push_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[hw/rtl/job_queue_with_keyed_removal_unit.sv]
// Top level of the job queue with keyed removal: command port, control and
// the chain of queue cells. Depends on jqkr_pkg and jqkr_cell.

// Each operation runs from start to done in this order: the cycle in
// which start is taken (busy low) registers the command and lets every cell
// compare its slot with the key, and the following cycle (busy high) finds
// the first matching cell from the head, shifts the later cells toward the
// head or writes a pushed entry at the tail, and registers the result. The
// result word is shown for one cycle with done high, and a new start is
// taken in that same cycle, but never while busy is high.
// The receiver cannot stall the result, so it must take every done word.
// out_handle, out_pid and out_name are zero whenever no entry is named.

module job_queue_with_keyed_removal_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [jqkr_pkg::FUNC_W-1:0]     func,
    input  logic [jqkr_pkg::HANDLE_W-1:0]   job_handle,
    input  logic [jqkr_pkg::PID_W-1:0]      job_pid,
    input  logic [jqkr_pkg::NAME_W-1:0]     job_name,
    input  logic [jqkr_pkg::POS_W-1:0]      position,
    output logic                            done,
    output logic [jqkr_pkg::STATUS_W-1:0]   status,
    output logic [jqkr_pkg::HANDLE_W-1:0]   out_handle,
    output logic [jqkr_pkg::PID_W-1:0]      out_pid,
    output logic [jqkr_pkg::NAME_W-1:0]     out_name,
    output logic [jqkr_pkg::OCC_W-1:0]      occupancy
);
    import jqkr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                accept;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [FUNC_W-1:0]   func_reg;
    entry_t              push_reg;
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    entry_t              result_reg;
    logic [OCC_W-1:0]    occupancy_reg;
    logic                shift_en;
    logic                push_en;
    cell_cmd_t           cmd;
    cell_exec_t          exec;
    chain_t              chain [DEPTH+1];
    entry_t              cell_entry [DEPTH];

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);

    // Sequencer: capture in S_IDLE, then execute in S_EXEC.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= busy;
        end
    end

    // Command word held for the execute cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg        <= func;
            push_reg.handle <= job_handle;
            push_reg.pid    <= job_pid;
            push_reg.name   <= job_name;
        end
    end

    // Broadcast of the search request to the cells.
    always_comb
    begin
        cmd.capture  = accept;
        cmd.func     = func;
        cmd.pid      = job_pid;
        cmd.name     = job_name;
        cmd.position = position;
        cmd.count    = count_reg;
    end

    // Outcome of the operation once the first hit is known.
    always_comb
    begin
        status_next = ST_OK;
        shift_en    = 1'b0;
        push_en     = 1'b0;
        count_next  = count_reg;
        if (busy)
        begin
            unique case (func_reg)
                FUNC_PUSH:
                begin
                    if (32'(count_reg) >= 32'(DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        push_en    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_POP, FUNC_RM_PID, FUNC_RM_NAME:
                begin
                    if (chain[DEPTH].found)
                    begin
                        shift_en   = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                FUNC_READ:
                begin
                    if (!chain[DEPTH].found)
                    begin
                        status_next = ST_INDEX;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        exec.shift_en  = shift_en;
        exec.push_en   = push_en;
        exec.push_data = push_reg;
        exec.count     = count_reg;
    end

    // Row of queue cells, head at index zero.
    assign chain[0].found = 1'b0;
    assign chain[0].sel   = '0;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        entry_t right;
        if (k == DEPTH - 1)
        begin : g_last
            assign right = cell_entry[k];
        end
        else
        begin : g_mid
            assign right = cell_entry[k+1];
        end

        jqkr_cell u_cell (
            .clk         (clk),
            .cell_idx    (IDX_W'(k)),
            .cmd         (cmd),
            .exec        (exec),
            .chain_in    (chain[k]),
            .chain_out   (chain[k+1]),
            .right_entry (right),
            .entry       (cell_entry[k])
        );
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            status_reg    <= status_next;
            result_reg    <= chain[DEPTH].sel;
            occupancy_reg <= OCC_W'(count_next);
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign out_handle = result_reg.handle;
    assign out_pid    = result_reg.pid;
    assign out_name   = result_reg.name;
    assign occupancy  = occupancy_reg;

endmodule

[hw/rtl/jqkr_checker.sv]
// Port-level checks for the job queue with keyed removal, bound to the top.
// Depends on jqkr_pkg and job_queue_with_keyed_removal_unit.

module jqkr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [jqkr_pkg::STATUS_W-1:0]   status,
    input logic [jqkr_pkg::HANDLE_W-1:0]   out_handle,
    input logic [jqkr_pkg::PID_W-1:0]      out_pid,
    input logic [jqkr_pkg::NAME_W-1:0]     out_name,
    input logic [jqkr_pkg::OCC_W-1:0]      occupancy
);
    import jqkr_pkg::*;

    // An accepted word is worked on in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // Every execute cycle yields exactly one result word.
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execute cycle gave no result");

    // No result word appears without an execute cycle before it.
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without an operation");

    // A rejected push only happens on a full queue.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> occupancy == OCC_W'(DEPTH))
        else $error("full status with room left");

    // Full and index errors name no entry.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_FULL || status == ST_INDEX)
        |-> out_handle == '0 && out_pid == '0 && out_name == '0)
        else $error("error result carries entry data");

endmodule

bind job_queue_with_keyed_removal_unit jqkr_checker u_jqkr_checker (.*);

[sim/tb.sv]
// Self-checking testbench for the job queue with keyed removal.
// Depends on jqkr_pkg and job_queue_with_keyed_removal_unit, and through it on jqkr_cell.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jqkr_pkg::*;

    localparam int N_DIR      = 20;
    localparam int N_RANDOM   = 630;
    localparam int CYCLE_CAP  = 100000;
    localparam int MAX_REPORT = 10;

    // Function codes that the block treats as no operation.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_mode_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    pid;
        logic [NAME_W-1:0]   name;
        logic [POS_W-1:0]    pos;
    } job_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    pid;
        logic [NAME_W-1:0]   name;
        logic [OCC_W-1:0]    occ;
    } job_result_t;

    typedef struct packed {
        job_word_t   word;
        logic        typed;
        job_result_t res;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   func;
    logic [HANDLE_W-1:0] job_handle;
    logic [PID_W-1:0]    job_pid;
    logic [NAME_W-1:0]   job_name;
    logic [POS_W-1:0]    position;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [PID_W-1:0]    out_pid;
    logic [NAME_W-1:0]   out_name;
    logic [OCC_W-1:0]    occupancy;

    // Shadow of the queue contents, head at index 0.
    entry_t      queue_img[$];
    // Results still owed by the block, oldest first.
    job_result_t owed_results[$];
    int          fail_count;
    int          cycle_count;

    dir_row_t           dir_rows[N_DIR];
    logic [PID_W-1:0]   pid_pool[6];
    logic [NAME_W-1:0]  name_pool[6];

    job_queue_with_keyed_removal_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .job_handle (job_handle),
        .job_pid    (job_pid),
        .job_name   (job_name),
        .position   (position),
        .done       (done),
        .status     (status),
        .out_handle (out_handle),
        .out_pid    (out_pid),
        .out_name   (out_name),
        .occupancy  (occupancy)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Apply one word to the shadow queue and return the result it must give.
    function automatic job_result_t apply_job(input job_word_t w);
        job_result_t r;
        int          hit;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        case (w.func)
            FUNC_PUSH:
            begin
                if (queue_img.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    queue_img.push_back('{handle: w.handle, pid: w.pid, name: w.name});
            end
            FUNC_POP:
            begin
                if (queue_img.size() == 0)
                    r.status = ST_EMPTY;
                else
                    hit = 0;
            end
            FUNC_RM_PID, FUNC_RM_NAME:
            begin
                r.status = ST_EMPTY;
                foreach (queue_img[k])
                begin
                    if (hit < 0 && ((w.func == FUNC_RM_PID) ? (queue_img[k].pid == w.pid)
                                                            : (queue_img[k].name == w.name)))
                        hit = k;
                end
            end
            FUNC_READ:
            begin
                if (w.pos >= queue_img.size())
                    r.status = ST_INDEX;
                else
                begin
                    r.handle = queue_img[w.pos].handle;
                    r.pid    = queue_img[w.pos].pid;
                    r.name   = queue_img[w.pos].name;
                end
            end
            default:
            begin
            end
        endcase
        // A removal hands back the entry and closes the gap behind it.
        if (hit >= 0)
        begin
            r.status = ST_OK;
            r.handle = queue_img[hit].handle;
            r.pid    = queue_img[hit].pid;
            r.name   = queue_img[hit].name;
            queue_img.delete(hit);
        end
        r.occ = OCC_W'(queue_img.size());
        return r;
    endfunction

    function automatic logic [NAME_W-1:0] any_name();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[NAME_W-1:0];
    endfunction

    // Keys come from a small pool half of the time so that duplicates occur.
    function automatic logic [PID_W-1:0] pick_pid();
        if ($urandom_range(0, 1) == 0)
            return pid_pool[$urandom_range(0, 5)];
        return PID_W'($urandom_range(0, 4194304));
    endfunction

    function automatic logic [NAME_W-1:0] pick_name();
        if ($urandom_range(0, 1) == 0)
            return name_pool[$urandom_range(0, 5)];
        return any_name();
    endfunction

    // Draw one random word whose operation mix follows the current mode.
    function automatic job_word_t make_word(input mix_mode_t mode);
        job_word_t w;
        int        roll;
        int        sz;
        int        k;
        w.handle = HANDLE_W'($urandom);
        w.pid    = pick_pid();
        w.name   = pick_name();
        w.pos    = POS_W'($urandom_range(0, 15));
        roll     = $urandom_range(0, 99);
        sz       = queue_img.size();
        case (mode)
            MODE_FILL:
                w.func = (roll < 85) ? FUNC_PUSH : FUNC_READ;
            MODE_DRAIN:
            begin
                if (roll < 30)
                    w.func = FUNC_POP;
                else if (roll < 60)
                    w.func = FUNC_RM_PID;
                else if (roll < 90)
                    w.func = FUNC_RM_NAME;
                else
                    w.func = FUNC_READ;
            end
            default:
            begin
                if (roll < 30)
                    w.func = FUNC_PUSH;
                else if (roll < 45)
                    w.func = FUNC_POP;
                else if (roll < 60)
                    w.func = FUNC_RM_PID;
                else if (roll < 75)
                    w.func = FUNC_RM_NAME;
                else if (roll < 95)
                    w.func = FUNC_READ;
                else
                    w.func = FUNC_SPARE_A + FUNC_W'($urandom_range(0, 2));
            end
        endcase
        // Most searches and reads aim at an entry that is really stored.
        if (sz > 0 && $urandom_range(0, 3) != 0)
        begin
            k = $urandom_range(0, sz - 1);
            if (w.func == FUNC_RM_PID)
                w.pid = queue_img[k].pid;
            if (w.func == FUNC_RM_NAME)
                w.name = queue_img[k].name;
            if (w.func == FUNC_READ)
                w.pos = POS_W'(k);
        end
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input job_word_t w, input logic typed, input job_result_t res,
                             input int gap);
        job_result_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        func       <= w.func;
        job_handle <= w.handle;
        job_pid    <= w.pid;
        job_name   <= w.name;
        position   <= w.pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_job(w);
        owed_results.push_back(typed ? res : predicted);
        @(negedge clk);
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic wait_until_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (owed_results.size() != 0);
    endtask

    // Compare each result word with the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (owed_results.size() == 0)
            begin
                if (fail_count < MAX_REPORT)
                    $display("unexpected result word: status %0d occ %0d", status, occupancy);
                fail_count++;
            end
            else
            begin
                job_result_t e;
                e = owed_results.pop_front();
                if (e.status !== status || e.handle !== out_handle || e.pid !== out_pid ||
                    e.name !== out_name || e.occ !== occupancy)
                begin
                    if (fail_count < MAX_REPORT)
                    begin
                        $write("mismatch: expected st %0d h %h p %h n %h occ %0d,",
                               e.status, e.handle, e.pid, e.name, e.occ);
                        $display(" got st %0d h %h p %h n %h occ %0d",
                                 status, out_handle, out_pid, out_name, occupancy);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int        items;
        int        left;
        bit        no_idle;
        bit        paused;
        mix_mode_t mode;

        fail_count  = 0;
        cycle_count = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = FUNC_PUSH;
        job_handle = '0;
        job_pid    = '0;
        job_name   = '0;
        position   = '0;

        // Directed words: empty-queue errors, field extremes, unused codes,
        // first-match removal, a name that differs in one bit, index limits.
        dir_rows[0]  = '{'{FUNC_POP, 16'h0, 23'h0, 48'h0, 4'd0}, 1'b1,
                         '{ST_EMPTY, 16'h0, 23'h0, 48'h0, 5'd0}};
        dir_rows[1]  = '{'{FUNC_RM_PID, 16'h0, 23'h0, 48'h0, 4'd0}, 1'b1,
                         '{ST_EMPTY, 16'h0, 23'h0, 48'h0, 5'd0}};
        dir_rows[2]  = '{'{FUNC_RM_NAME, 16'h0, 23'h0, 48'h0, 4'd0}, 1'b1,
                         '{ST_EMPTY, 16'h0, 23'h0, 48'h0, 5'd0}};
        dir_rows[3]  = '{'{FUNC_READ, 16'h0, 23'h0, 48'h0, 4'd0}, 1'b1,
                         '{ST_INDEX, 16'h0, 23'h0, 48'h0, 5'd0}};
        dir_rows[4]  = '{'{FUNC_READ, 16'h0, 23'h0, 48'h0, 4'd15}, 1'b1,
                         '{ST_INDEX, 16'h0, 23'h0, 48'h0, 5'd0}};
        dir_rows[5]  = '{'{FUNC_SPARE_A, 16'hffff, 23'h400000, 48'hffffffffffff, 4'd15}, 1'b1,
                         '{ST_OK, 16'h0, 23'h0, 48'h0, 5'd0}};
        dir_rows[6]  = '{'{FUNC_PUSH, 16'hffff, 23'h400000, 48'hffffffffffff, 4'd15}, 1'b1,
                         '{ST_OK, 16'h0, 23'h0, 48'h0, 5'd1}};
        dir_rows[7]  = '{'{FUNC_PUSH, 16'h0, 23'h0, 48'h0, 4'd0}, 1'b1,
                         '{ST_OK, 16'h0, 23'h0, 48'h0, 5'd2}};
        dir_rows[8]  = '{'{FUNC_PUSH, 16'h1234, 23'h400000, 48'h4a4f42303031, 4'd0}, 1'b0, '0};
        dir_rows[9]  = '{'{FUNC_READ, 16'h0, 23'h0, 48'h0, 4'd0}, 1'b1,
                         '{ST_OK, 16'hffff, 23'h400000, 48'hffffffffffff, 5'd3}};
        dir_rows[10] = '{'{FUNC_READ, 16'h0, 23'h0, 48'h0, 4'd3}, 1'b1,
                         '{ST_INDEX, 16'h0, 23'h0, 48'h0, 5'd3}};
        dir_rows[11] = '{'{FUNC_READ, 16'h0, 23'h0, 48'h0, 4'd2}, 1'b0, '0};
        dir_rows[12] = '{'{FUNC_RM_PID, 16'h0, 23'h400000, 48'h0, 4'd0}, 1'b0, '0};
        dir_rows[13] = '{'{FUNC_RM_NAME, 16'h0, 23'h0, 48'h4a4f42303030, 4'd0}, 1'b0, '0};
        dir_rows[14] = '{'{FUNC_RM_NAME, 16'h0, 23'h0, 48'h4a4f42303031, 4'd0}, 1'b0, '0};
        dir_rows[15] = '{'{FUNC_SPARE_B, 16'h0, 23'h0, 48'h0, 4'd0}, 1'b0, '0};
        dir_rows[16] = '{'{FUNC_SPARE_C, 16'h0, 23'h0, 48'h0, 4'd0}, 1'b0, '0};
        dir_rows[17] = '{'{FUNC_RM_PID, 16'h0, 23'h1, 48'h0, 4'd0}, 1'b0, '0};
        dir_rows[18] = '{'{FUNC_POP, 16'h0, 23'h0, 48'h0, 4'd0}, 1'b0, '0};
        dir_rows[19] = '{'{FUNC_POP, 16'h0, 23'h0, 48'h0, 4'd0}, 1'b1,
                         '{ST_EMPTY, 16'h0, 23'h0, 48'h0, 5'd0}};

        for (int i = 0; i < 6; i++)
        begin
            pid_pool[i]  = PID_W'($urandom_range(0, 4194304));
            name_pool[i] = any_name();
        end

        // Hold reset, then release it at a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res,
                      $urandom_range(0, 4));
        wait_until_drained();

        // Random part: phases of filling, draining and mixed traffic.
        items  = 0;
        paused = 1'b0;
        while (items < N_RANDOM)
        begin
            mode    = mix_mode_t'($urandom_range(0, 2));
            left    = $urandom_range(20, 50);
            no_idle = ($urandom_range(0, 3) == 0);
            if (!paused && items >= N_RANDOM / 2)
            begin
                wait_until_drained();
                paused = 1'b1;
            end
            while (left > 0 && items < N_RANDOM)
            begin
                send_word(make_word(mode), 1'b0, '0, no_idle ? 0 : $urandom_range(0, 4));
                left--;
                items++;
            end
        end

        // Let the last words come back, then let the clock run idle.
        wait_until_drained();
        repeat (8) @(posedge clk);

        if (fail_count == 0 && owed_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/jqkr_pkg.sv
hw/rtl/jqkr_cell.sv
hw/rtl/job_queue_with_keyed_removal_unit.sv
hw/rtl/jqkr_checker.sv
sim/tb.sv
